// ===== hw/rtl/rle8_pkg.sv =====
// Package for the byte run-length decoder: phase encoding, command modes,
// the run descriptor passed from the front to the back, and queue sizing.
// No dependencies.
package rle8_pkg;

  typedef enum logic [1:0] {
    PH_CMD  = 2'd0,
    PH_FILL = 2'd1,
    PH_LIT  = 2'd2
  } phase_t;

  localparam logic [1:0] MODE_ZERO = 2'b00;
  localparam logic [1:0] MODE_ONES = 2'b01;
  localparam logic [1:0] MODE_FILL = 2'b10;
  localparam logic [1:0] MODE_LIT  = 2'b11;

  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] BYTE_ONES = 8'hFF;

  localparam int LEN_W  = 6;
  localparam int PEND_W = 7;
  localparam logic [PEND_W-1:0] PEND_MAX = 7'd64;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  typedef struct packed {
    logic [7:0]       value;
    logic [LEN_W-1:0] len_m1;
    logic             eos;
  } job_t;

endpackage

// ===== hw/rtl/rle8_front.sv =====
// Front end: accepts compressed bytes, tracks the command phase and turns
// each byte that yields output into a run descriptor. Depends on rle8_pkg.
module rle8_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    in_byte,
  input  logic          q_full,
  output logic          q_push,
  output rle8_pkg::job_t q_job
);
  import rle8_pkg::*;

  phase_t              phase_r, phase_nxt;
  logic [PEND_W-1:0]   pend_r, pend_nxt;
  logic                accept;
  logic [1:0]          mode;
  logic [LEN_W-1:0]    raw_len;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign mode     = in_byte[7:6];
  assign raw_len  = in_byte[LEN_W-1:0];

  always_comb begin
    phase_nxt = phase_r;
    pend_nxt  = pend_r;
    if (accept) begin
      unique case (phase_r)
        PH_FILL: begin
          phase_nxt = PH_CMD;
          pend_nxt  = '0;
        end
        PH_LIT: begin
          if (pend_r <= PEND_W'(1)) begin
            phase_nxt = PH_CMD;
            pend_nxt  = '0;
          end else begin
            pend_nxt = pend_r - PEND_W'(1);
          end
        end
        default: begin
          phase_nxt = PH_CMD;
          pend_nxt  = '0;
          unique case (mode)
            MODE_FILL: begin
              if (raw_len != '0) begin
                phase_nxt = PH_FILL;
                pend_nxt  = {1'b0, raw_len} + PEND_W'(1);
              end
            end
            MODE_LIT: begin
              phase_nxt = PH_LIT;
              pend_nxt  = {1'b0, raw_len} + PEND_W'(1);
            end
            default: ;
          endcase
        end
      endcase
    end
  end

  always_comb begin
    q_push       = 1'b0;
    q_job.value  = in_byte;
    q_job.len_m1 = '0;
    q_job.eos    = 1'b0;
    unique case (phase_r)
      PH_FILL: begin
        q_push = accept;
        if (pend_r == '0) begin
          q_job.len_m1 = '0;
        end else if (pend_r > PEND_MAX) begin
          q_job.len_m1 = '1;
        end else begin
          q_job.len_m1 = LEN_W'(pend_r - PEND_W'(1));
        end
      end
      PH_LIT: begin
        q_push = accept;
      end
      default: begin
        unique case (mode)
          MODE_ZERO: begin
            q_push       = accept;
            q_job.value  = BYTE_ZERO;
            q_job.len_m1 = raw_len;
          end
          MODE_ONES: begin
            q_push       = accept;
            q_job.value  = BYTE_ONES;
            q_job.len_m1 = raw_len;
          end
          MODE_FILL: begin
            q_push      = accept && (raw_len == '0);
            q_job.value = BYTE_ZERO;
            q_job.eos   = 1'b1;
          end
          default: ;
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_CMD;
      pend_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule

// ===== hw/rtl/rle8_queue.sv =====
// Short queue of run descriptors between the front and back ends.
// Depends on rle8_pkg.
module rle8_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rle8_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output rle8_pkg::job_t q_job
);
  import rle8_pkg::*;

  job_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_r, wr_nxt;
  logic [Q_AW-1:0] rd_r, rd_nxt;
  logic [Q_AW:0]   cnt_r, cnt_nxt;

  assign full    = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_job   = mem_r[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + Q_AW'(1) : wr_r;
    rd_nxt  = pop ? rd_r + Q_AW'(1) : rd_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + (Q_AW+1)'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - (Q_AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_job;
    end
  end

endmodule

// ===== hw/rtl/rle8_back.sv =====
// Back end: plays each run descriptor out one byte per cycle into the
// output register while out_stall does not hold it. Depends on rle8_pkg.
module rle8_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  rle8_pkg::job_t q_job,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_byte,
  output logic           out_last_of_run,
  output logic           out_end_of_stream
);
  import rle8_pkg::*;

  logic             busy_r, busy_nxt;
  logic             out_valid_r, out_valid_nxt;
  job_t             job_r;
  logic [LEN_W-1:0] cnt_r;
  logic [7:0]       out_byte_r;
  logic             out_last_r;
  logic             out_eos_r;
  logic             slot;
  logic             emit;
  logic             finish;

  assign slot   = !out_valid_r || !out_stall;
  assign emit   = busy_r && slot;
  assign finish = emit && (cnt_r == '0);
  assign q_pop  = q_valid && (!busy_r || finish);

  always_comb begin
    busy_nxt = busy_r;
    if (q_pop) begin
      busy_nxt = 1'b1;
    end else if (finish) begin
      busy_nxt = 1'b0;
    end
    out_valid_nxt = emit ? 1'b1 : (slot ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_job;
      cnt_r <= q_job.len_m1;
    end else if (emit) begin
      cnt_r <= cnt_r - LEN_W'(1);
    end
    if (emit) begin
      out_byte_r <= job_r.value;
      out_last_r <= (cnt_r == '0);
      out_eos_r  <= job_r.eos;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_byte          = out_byte_r;
  assign out_last_of_run   = out_last_r;
  assign out_end_of_stream = out_eos_r;

endmodule

// ===== hw/rtl/rle8_fill_decoder_core.sv =====
// Byte run-length decoder top level: front end, descriptor queue, back end.
// Depends on rle8_pkg, rle8_front, rle8_queue and rle8_back.
//
// Usage:
//   Input channel in_valid / in_stall / in_byte carries one compressed byte
//   per transaction: a command, a fill value or a literal byte.
//   Output channel out_valid / out_stall carries one decoded byte per
//   transaction with out_last_of_run on the final byte caused by an input
//   byte and out_end_of_stream (with out_byte zero) on the end marker.
//   Path: a byte that yields output is written into the queue, popped into
//   the back's descriptor register, then played into the output register.
//   Throughput: the front takes one byte per cycle while in_stall is low;
//   the back plays runs out at one result per cycle while out_stall is
//   low. Run-opening commands consume an input byte and give no output.
//   The four-entry descriptor queue absorbs bursts; when it fills,
//   in_stall rises.
//   Reset (rst_n low, synchronous) returns to command phase, empties the
//   queue and drops any result not yet taken.
//   A stalled result holds in the output register; the back pauses and
//   the queue keeps filling until it is full.
module rle8_fill_decoder_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last_of_run,
  output logic       out_end_of_stream
);
  import rle8_pkg::*;

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_valid;
  job_t push_job;
  job_t q_job;

  rle8_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  rle8_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_job    (q_job)
  );

  rle8_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_job             (q_job),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_last_of_run   (out_last_of_run),
    .out_end_of_stream (out_end_of_stream)
  );

`ifndef NO_ASSERTIONS
  a_eos_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_stream |-> out_last_of_run && (out_byte == BYTE_ZERO))
    else $error("end marker without last flag or with nonzero byte");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("descriptor popped from empty queue");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("descriptor pushed into full queue");
`endif

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for rle8_fill_decoder_core: directed and random byte streams,
// with the decoded output checked against an in-bench decoder model.
// Depends on rle8_pkg and rle8_fill_decoder_core.
module tb_top;
  import rle8_pkg::*;

  typedef struct {
    logic [7:0] value;
    logic       last;
    logic       eos;
  } dec_result_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       out_last_of_run;
  logic       out_end_of_stream;

  phase_t            dec_phase = PH_CMD;
  logic [PEND_W-1:0] dec_pend = '0;
  dec_result_t       expected_bytes[$];

  int  err_cnt = 0;
  int  sent_cnt = 0;
  int  stall_hold = 0;
  bit  idle_on = 1'b1;

  rle8_fill_decoder_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_byte           (in_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_last_of_run   (out_last_of_run),
    .out_end_of_stream (out_end_of_stream)
  );

  always #4 clk = ~clk;

  function automatic void push_result(logic [7:0] value, logic last, logic eos);
    dec_result_t r;
    r.value = value;
    r.last  = last;
    r.eos   = eos;
    expected_bytes.push_back(r);
  endfunction

  function automatic void push_run(logic [7:0] value, int n);
    for (int i = 0; i < n; i++) begin
      push_result(value, (i == n - 1), 1'b0);
    end
  endfunction

  function automatic void decode_byte(logic [7:0] b);
    int n;
    case (dec_phase)
      PH_FILL: begin
        if (dec_pend == 0) begin
          n = 1;
        end else if (dec_pend > PEND_MAX) begin
          n = int'(PEND_MAX);
        end else begin
          n = int'(dec_pend);
        end
        push_run(b, n);
        dec_phase = PH_CMD;
        dec_pend  = '0;
      end
      PH_LIT: begin
        push_result(b, 1'b1, 1'b0);
        if (dec_pend <= 1) begin
          dec_phase = PH_CMD;
          dec_pend  = '0;
        end else begin
          dec_pend = dec_pend - 1'b1;
        end
      end
      default: begin
        n = int'(b[5:0]) + 1;
        dec_phase = PH_CMD;
        dec_pend  = '0;
        case (b[7:6])
          MODE_ZERO: push_run(BYTE_ZERO, n);
          MODE_ONES: push_run(BYTE_ONES, n);
          MODE_FILL: begin
            if (n == 1) begin
              push_result(BYTE_ZERO, 1'b1, 1'b1);
            end else begin
              dec_phase = PH_FILL;
              dec_pend  = PEND_W'(n);
            end
          end
          default: begin
            dec_phase = PH_LIT;
            dec_pend  = PEND_W'(n);
          end
        endcase
      end
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    bit taken;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    decode_byte(b);
    sent_cnt++;
  endtask

  task automatic send_random_sequence();
    logic [1:0] mode;
    logic [5:0] len_m1;
    logic [7:0] cmd;
    int         n;
    if ($urandom_range(0, 7) == 0) begin
      send_byte(8'($urandom));
    end else begin
      mode   = 2'($urandom_range(0, 3));
      len_m1 = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                           : 6'($urandom_range(0, 7));
      cmd = {mode, len_m1};
      if ($urandom_range(0, 15) == 0) begin
        cmd = {MODE_FILL, 6'd0};
      end
      send_byte(cmd);
      n = int'(cmd[5:0]) + 1;
      if (cmd[7:6] == MODE_FILL && n > 1) begin
        send_byte(8'($urandom));
      end else if (cmd[7:6] == MODE_LIT) begin
        if ($urandom_range(0, 9) == 0) begin
          n = $urandom_range(0, n - 1);
        end
        repeat (n) send_byte(8'($urandom));
      end
    end
  endtask

  task automatic test_directed_runs();
    send_byte({MODE_ZERO, 6'd0});
    send_byte({MODE_ZERO, 6'd63});
    send_byte({MODE_ONES, 6'd0});
    send_byte({MODE_ONES, 6'd63});
    send_byte({MODE_FILL, 6'd0});
    send_byte({MODE_FILL, 6'd0});
    send_byte({MODE_ONES, 6'd1});
  endtask

  task automatic test_directed_fill_literal();
    send_byte({MODE_FILL, 6'd1});
    send_byte(8'hA5);
    send_byte({MODE_FILL, 6'd63});
    send_byte(8'h00);
    send_byte({MODE_FILL, 6'd32});
    send_byte(8'hFF);
    send_byte({MODE_LIT, 6'd0});
    send_byte(8'h5A);
    send_byte({MODE_LIT, 6'd3});
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte({MODE_FILL, 6'd0});
    send_byte({MODE_LIT, 6'd63});
  endtask

  task automatic test_random_stream(input int target);
    while (sent_cnt < target) begin
      send_random_sequence();
    end
  endtask

  task automatic test_backpressure();
    stall_hold = 300;
    send_byte({MODE_LIT, 6'd15});
    repeat (16) send_byte(8'($urandom));
    repeat (6) send_byte({MODE_ZERO, 6'd3});
    send_byte({MODE_FILL, 6'd4});
    send_byte(8'h3C);
  endtask

  task automatic test_no_idle(input int target);
    idle_on = 1'b0;
    test_random_stream(target);
  endtask

  initial begin : rx_stall_gen
    int burst;
    burst = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_hold > 0) begin
        stall_hold--;
        out_stall <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        out_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 11) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    dec_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) begin
          $display("unexpected transaction: byte %02h last %b eos %b",
                   out_byte, out_last_of_run, out_end_of_stream);
        end
      end else begin
        exp_r = expected_bytes.pop_front();
        if (out_byte !== exp_r.value || out_last_of_run !== exp_r.last ||
            out_end_of_stream !== exp_r.eos) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("mismatch: expected byte %02h last %b eos %b, got %02h %b %b",
                     exp_r.value, exp_r.last, exp_r.eos,
                     out_byte, out_last_of_run, out_end_of_stream);
          end
        end
      end
    end
  end

  initial begin
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_byte  <= 8'h00;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_runs();
    test_directed_fill_literal();
    test_random_stream(300);
    test_backpressure();
    test_random_stream(410);
    test_no_idle(470);
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) begin
      @(posedge clk);
    end
    repeat (100) @(posedge clk);
    if (expected_bytes.size() != 0) begin
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
